// ===== sv/bhe_pkg.sv =====
// shared types and constants for the binned histogram engine
`timescale 1ns / 1ps

package bhe_pkg;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_MUL,
        F_FIN
    } front_state_t;

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_READ,
        B_MUL,
        B_RES
    } back_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        oor;
        logic [31:0] quot;
        logic [31:0] weight;
        logic [31:0] bin_low;
        logic [31:0] bin_high;
        logic [31:0] bw;
    } job_t;

endpackage

// ===== sv/bhe_front.sv =====
// front end: takes transactions, divides by the bin width, builds jobs
`timescale 1ns / 1ps

module bhe_front #(
    parameter int NUM_BINS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [31:0]        value,
    input  logic signed [31:0] weight,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    output logic               job_valid,
    output bhe_pkg::job_t      job,
    input  logic               job_ready
);

    bhe_pkg::front_state_t state_reg, state_next;

    logic [31:0] bw_reg;
    logic [1:0]  kind_reg;
    logic [31:0] weight_reg;
    logic [31:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] blow_reg;
    logic        oor_reg;
    logic        zero_reg;

    logic [32:0] shifted;
    logic [32:0] trial;
    logic [63:0] prod;
    logic [32:0] high_sum;
    logic        accept;

    assign shifted  = {rem_reg, dvd_reg[31]};
    assign trial    = shifted - {1'b0, bw_reg};
    assign prod     = dvd_reg * bw_reg;
    assign high_sum = {1'b0, blow_reg} + {1'b0, bw_reg} - 33'd1;
    assign in_ready = (state_reg == bhe_pkg::F_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bhe_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_valid  = 1'b0;
        unique case (state_reg)
            bhe_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    if (kind == bhe_pkg::KIND_CLEAR || bw_reg == 32'd0)
                    begin
                        state_next = bhe_pkg::F_FIN;
                    end
                    else
                    begin
                        state_next = bhe_pkg::F_DIV;
                    end
                end
            end
            bhe_pkg::F_DIV:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = bhe_pkg::F_MUL;
                end
            end
            bhe_pkg::F_MUL:
            begin
                state_next = bhe_pkg::F_FIN;
            end
            bhe_pkg::F_FIN:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = bhe_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = bhe_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg <= 32'd1;
        end
        else if (accept && kind == bhe_pkg::KIND_CLEAR)
        begin
            bw_reg <= 32'd1;
        end
        else if (cfg_wr_en)
        begin
            bw_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            bhe_pkg::F_IDLE:
            begin
                kind_reg   <= kind;
                weight_reg <= weight;
                dvd_reg    <= value;
                rem_reg    <= 32'd0;
                cnt_reg    <= 5'd0;
                blow_reg   <= 32'd0;
                zero_reg   <= (bw_reg == 32'd0);
                oor_reg    <= (kind != bhe_pkg::KIND_CLEAR) && (bw_reg == 32'd0);
            end
            bhe_pkg::F_DIV:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    dvd_reg <= {dvd_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[31:0];
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                end
            end
            bhe_pkg::F_MUL:
            begin
                blow_reg <= prod[31:0];
                oor_reg  <= (dvd_reg >= 32'(NUM_BINS));
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        job.kind    = kind_reg;
        job.oor     = oor_reg;
        job.quot    = dvd_reg;
        job.weight  = weight_reg;
        job.bin_low = blow_reg;
        job.bw      = bw_reg;
        if (kind_reg == bhe_pkg::KIND_CLEAR)
        begin
            job.bin_high = 32'd0;
        end
        else if (zero_reg || high_sum[32])
        begin
            job.bin_high = 32'hFFFF_FFFF;
        end
        else
        begin
            job.bin_high = high_sum[31:0];
        end
    end

endmodule

// ===== sv/bhe_queue.sv =====
// small job queue between front and back
`timescale 1ns / 1ps

module bhe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  bhe_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_pop,
    output bhe_pkg::job_t rd_data
);

    bhe_pkg::job_t slot_reg [bhe_pkg::QUEUE_DEPTH];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (fill_reg != 2'(bhe_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/bhe_back.sv =====
// back end: bin store read-modify-write, statistics and result register
`timescale 1ns / 1ps

module bhe_back #(
    parameter int NUM_BINS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_pop,
    input  bhe_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] count,
    output logic               present,
    output logic               out_of_range,
    output logic [31:0]        bin_low,
    output logic [31:0]        bin_high,
    output logic [31:0]        lowest_start,
    output logic [31:0]        highest_start,
    output logic               empty_res,
    output logic [10:0]        occupied_bins,
    output logic signed [63:0] total_count
);

    localparam int IW = $clog2(NUM_BINS);
    localparam int PW = $clog2(NUM_BINS + 1);

    bhe_pkg::back_state_t state_reg, state_next;

    logic [32:0] mem [NUM_BINS];
    logic [32:0] rd_reg;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] sweep_reg;

    bhe_pkg::job_t cur_reg;
    logic          sweep_after_reg;
    logic [IW-1:0] lowest_reg;
    logic [IW-1:0] highest_reg;
    logic [PW-1:0] total_reg;
    logic [63:0]   sum_reg;
    logic [31:0]   res_count_reg;
    logic          res_present_reg;
    logic [31:0]   lo_prod_reg;
    logic [31:0]   hi_prod_reg;

    logic          out_valid_reg;
    logic [31:0]   count_reg;
    logic          present_reg;
    logic          oor_out_reg;
    logic [31:0]   bin_low_reg;
    logic [31:0]   bin_high_reg;
    logic [31:0]   lowest_start_reg;
    logic [31:0]   highest_start_reg;
    logic          empty_reg;
    logic [10:0]   occupied_reg;
    logic [63:0]   total_count_reg;

    logic          out_load;
    logic [IW-1:0] idx;
    logic          was_present;
    logic [31:0]   base;
    logic [31:0]   added;
    logic [IW+31:0] lo_prod;
    logic [IW+31:0] hi_prod;

    assign rd_addr     = job.quot[IW-1:0];
    assign idx         = cur_reg.quot[IW-1:0];
    assign was_present = rd_reg[32];
    assign base        = was_present ? rd_reg[31:0] : 32'd0;
    assign added       = base + cur_reg.weight;
    assign lo_prod     = lowest_reg * cur_reg.bw;
    assign hi_prod     = highest_reg * cur_reg.bw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bhe_pkg::B_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            bhe_pkg::B_SWEEP:
            begin
                if (sweep_reg == IW'(NUM_BINS - 1))
                begin
                    state_next = bhe_pkg::B_IDLE;
                end
            end
            bhe_pkg::B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    if (job.kind == bhe_pkg::KIND_CLEAR || job.oor)
                    begin
                        state_next = bhe_pkg::B_MUL;
                    end
                    else
                    begin
                        state_next = bhe_pkg::B_READ;
                    end
                end
            end
            bhe_pkg::B_READ:
            begin
                state_next = bhe_pkg::B_MUL;
            end
            bhe_pkg::B_MUL:
            begin
                state_next = bhe_pkg::B_RES;
            end
            bhe_pkg::B_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = sweep_after_reg ? bhe_pkg::B_SWEEP : bhe_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = bhe_pkg::B_IDLE;
            end
        endcase
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
        if (state_reg == bhe_pkg::B_SWEEP)
        begin
            mem[sweep_reg] <= 33'd0;
        end
        else if (state_reg == bhe_pkg::B_READ)
        begin
            case (cur_reg.kind)
                bhe_pkg::KIND_ADD:
                begin
                    mem[idx] <= {1'b1, added};
                end
                bhe_pkg::KIND_GET:
                begin
                    mem[idx] <= {1'b1, base};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg       <= '0;
            sweep_after_reg <= 1'b0;
            lowest_reg      <= '0;
            highest_reg     <= '0;
            total_reg       <= '0;
            sum_reg         <= 64'd0;
        end
        else
        begin
            case (state_reg)
                bhe_pkg::B_SWEEP:
                begin
                    sweep_reg <= sweep_reg + IW'(1);
                end
                bhe_pkg::B_IDLE:
                begin
                    sweep_reg <= '0;
                    if (job_valid)
                    begin
                        sweep_after_reg <= (job.kind == bhe_pkg::KIND_CLEAR);
                        if (job.kind == bhe_pkg::KIND_CLEAR)
                        begin
                            lowest_reg  <= '0;
                            highest_reg <= '0;
                            total_reg   <= '0;
                            sum_reg     <= 64'd0;
                        end
                    end
                end
                bhe_pkg::B_READ:
                begin
                    if (cur_reg.kind == bhe_pkg::KIND_ADD)
                    begin
                        sum_reg <= sum_reg + {{32{cur_reg.weight[31]}}, cur_reg.weight};
                    end
                    if (!was_present && cur_reg.kind != bhe_pkg::KIND_QUERY)
                    begin
                        total_reg <= total_reg + PW'(1);
                        if (total_reg == '0)
                        begin
                            lowest_reg  <= idx;
                            highest_reg <= idx;
                        end
                        else
                        begin
                            if (idx < lowest_reg)
                            begin
                                lowest_reg <= idx;
                            end
                            if (idx > highest_reg)
                            begin
                                highest_reg <= idx;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            bhe_pkg::B_IDLE:
            begin
                cur_reg         <= job;
                res_count_reg   <= 32'd0;
                res_present_reg <= 1'b0;
            end
            bhe_pkg::B_READ:
            begin
                case (cur_reg.kind)
                    bhe_pkg::KIND_ADD:
                    begin
                        res_count_reg   <= added;
                        res_present_reg <= 1'b1;
                    end
                    bhe_pkg::KIND_GET:
                    begin
                        res_count_reg   <= base;
                        res_present_reg <= 1'b1;
                    end
                    default:
                    begin
                        res_count_reg   <= base;
                        res_present_reg <= was_present;
                    end
                endcase
            end
            bhe_pkg::B_MUL:
            begin
                lo_prod_reg <= lo_prod[31:0];
                hi_prod_reg <= hi_prod[31:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            count_reg         <= res_count_reg;
            present_reg       <= res_present_reg;
            oor_out_reg       <= cur_reg.oor;
            bin_low_reg       <= cur_reg.bin_low;
            bin_high_reg      <= cur_reg.bin_high;
            empty_reg         <= (total_reg == '0);
            lowest_start_reg  <= (total_reg == '0) ? 32'd0 : lo_prod_reg;
            highest_start_reg <= (total_reg == '0) ? 32'd0 : hi_prod_reg;
            occupied_reg      <= 11'(total_reg);
            total_count_reg   <= sum_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign count         = count_reg;
    assign present       = present_reg;
    assign out_of_range  = oor_out_reg;
    assign bin_low       = bin_low_reg;
    assign bin_high      = bin_high_reg;
    assign lowest_start  = lowest_start_reg;
    assign highest_start = highest_start_reg;
    assign empty_res     = empty_reg;
    assign occupied_bins = occupied_reg;
    assign total_count   = total_count_reg;

endmodule

// ===== sv/binned_histogram_engine_core.sv =====
// top level of the binned histogram engine
`timescale 1ns / 1ps

// usage:
// input channel in_valid/in_ready carries kind, value and weight; kind is
// add, get, query or clear. every transaction yields exactly one result on
// out_valid/out_ready, in order.
// bin_width is written through cfg_wr_en/cfg_wr_data, by the user only while
// the block is idle, which the block does not enforce; a clear resets it to 1.
// the front end runs a restoring divider, one quotient bit per cycle, then a
// multiply for the bin range; a clear, or any item while bin_width is 0,
// skips both. the back end reads the bin store for each in-range add, get
// or query, writes it back for add and get, and overlaps with the front
// end through a two-entry queue, so new items are taken while it is busy.
// after reset, and after each clear, the back end sweeps all NUM_BINS entries
// of the bin store, one entry per cycle; items queue up meanwhile.
// when the receiver stalls, the result register holds; the front end keeps
// taking items until the queue fills, then in_ready drops.
module binned_histogram_engine_core #(
    parameter int NUM_BINS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [31:0]        value,
    input  logic signed [31:0] weight,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] count,
    output logic               present,
    output logic               out_of_range,
    output logic [31:0]        bin_low,
    output logic [31:0]        bin_high,
    output logic [31:0]        lowest_start,
    output logic [31:0]        highest_start,
    output logic               empty_res,
    output logic [10:0]        occupied_bins,
    output logic signed [63:0] total_count
);

    logic          f_valid;
    logic          f_ready;
    bhe_pkg::job_t f_job;
    logic          q_valid;
    logic          q_pop;
    bhe_pkg::job_t q_job;

    bhe_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .weight      (weight),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_valid   (f_valid),
        .job         (f_job),
        .job_ready   (f_ready)
    );

    bhe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_job)
    );

    bhe_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_valid),
        .job_pop       (q_pop),
        .job           (q_job),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .count         (count),
        .present       (present),
        .out_of_range  (out_of_range),
        .bin_low       (bin_low),
        .bin_high      (bin_high),
        .lowest_start  (lowest_start),
        .highest_start (highest_start),
        .empty_res     (empty_res),
        .occupied_bins (occupied_bins),
        .total_count   (total_count)
    );

endmodule
